// ===== hdl/julia_escape_time_macros.svh =====
// ----------------------------------------------------------------------------
// julia_escape_time_macros.svh
// Assertion shorthands for the escape-time controller, jet_ctrl. Each expects clk_i
// and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_MACROS_SVH
`define JULIA_ESCAPE_TIME_MACROS_SVH

// Same-cycle implication
`define JET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define JET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/jet_pkg.sv =====
// ----------------------------------------------------------------------------
// jet_pkg
// Shared types, constants and saturation helper for the escape-time block.
// ----------------------------------------------------------------------------
package jet_pkg;

  localparam int unsigned FracBitsDef = 26;
  localparam int unsigned DataW       = 32;
  localparam int unsigned LimitW      = 16;
  localparam int unsigned CountW      = LimitW + 1;
  localparam int unsigned AddrW       = 4;
  localparam logic [LimitW-1:0] LimitRst = 16'd10000;

  // Register offsets (byte address bits [3:2])
  localparam logic [1:0] RegBound = 2'd0;
  localparam logic [1:0] RegCReal = 2'd1;
  localparam logic [1:0] RegCImag = 2'd2;
  localparam logic [1:0] RegLimit = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic load;   // take the start point
    logic mul;    // register the three products
    logic scale;  // register scaled, saturated re/im
    logic upd;    // register z = sat(z*z + c)
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic escape; // new real part reaches the bound
  } status_t;

  // Clamp a wide signed value to the 32-bit range
  function automatic logic signed [DataW-1:0] sat32(input logic signed [64:0] v);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi = 65'sh0_7FFF_FFFF;
    lo = -65'sh0_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[DataW-1:0];
    end
  endfunction

endpackage

// ===== hdl/jet_regs.sv =====
// ----------------------------------------------------------------------------
// jet_regs
// APB register file: escape bound, constant c and iteration limit.
// ----------------------------------------------------------------------------
module jet_regs import jet_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output logic signed [DataW-1:0] bound_o,
  output logic signed [DataW-1:0] c_real_o,
  output logic signed [DataW-1:0] c_imag_o,
  output logic [LimitW-1:0]       limit_o
);

  logic signed [DataW-1:0] bound_q, c_real_q, c_imag_q;
  logic [LimitW-1:0]       limit_q;
  logic                    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q  <= '0;
      c_real_q <= '0;
      c_imag_q <= '0;
      limit_q  <= LimitRst;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegBound: bound_q  <= pwdata;
        RegCReal: c_real_q <= pwdata;
        RegCImag: c_imag_q <= pwdata;
        RegLimit: limit_q  <= pwdata[LimitW-1:0];
        default:  ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (paddr[3:2])
      RegBound: prdata = bound_q;
      RegCReal: prdata = c_real_q;
      RegCImag: prdata = c_imag_q;
      RegLimit: prdata = {{(32-LimitW){1'b0}}, limit_q};
      default:  prdata = '0;
    endcase
  end

  assign bound_o  = bound_q;
  assign c_real_o = c_real_q;
  assign c_imag_o = c_imag_q;
  assign limit_o  = limit_q;

endmodule

// ===== hdl/jet_dpath.sv =====
// ----------------------------------------------------------------------------
// jet_dpath
// Complex square-and-add datapath: products, scaling, add of c, bound test.
// ----------------------------------------------------------------------------
module jet_dpath import jet_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic signed [DataW-1:0] start_real_i,
  input  logic signed [DataW-1:0] start_imag_i,
  input  logic signed [DataW-1:0] bound_i,
  input  logic signed [DataW-1:0] c_real_i,
  input  logic signed [DataW-1:0] c_imag_i,
  input  cmd_t                    cmd_i,
  output status_t                 status_o
);

  logic signed [DataW-1:0]   x_q, y_q, re_q, im_q;
  logic signed [2*DataW-1:0] xx_q, yy_q, xy_q;
  logic signed [2*DataW-1:0] xx_d, yy_d, xy_d;
  logic signed [64:0]        sq, sq_sh, xy_sh;
  logic signed [DataW-1:0]   re_d, im_d, x_d, y_d;

  // Stage 1: products
  assign xx_d = x_q * x_q;
  assign yy_d = y_q * y_q;
  assign xy_d = x_q * y_q;

  // Stage 2: x^2 - y^2 and 2xy, floor-scaled and clamped
  assign sq    = 65'(xx_q) - 65'(yy_q);
  assign sq_sh = sq >>> FRAC_BITS;
  assign xy_sh = 65'(xy_q) >>> (FRAC_BITS - 1);
  assign re_d  = sat32(sq_sh);
  assign im_d  = sat32(xy_sh);

  // Stage 3: add c, clamp
  assign x_d = sat32(65'(re_q) + 65'(c_real_i));
  assign y_d = sat32(65'(im_q) + 65'(c_imag_i));

  assign status_o.escape = (x_d >= bound_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= start_real_i;
      y_q <= start_imag_i;
    end else if (cmd_i.upd) begin
      x_q <= x_d;
      y_q <= y_d;
    end
    if (cmd_i.mul) begin
      xx_q <= xx_d;
      yy_q <= yy_d;
      xy_q <= xy_d;
    end
    if (cmd_i.scale) begin
      re_q <= re_d;
      im_q <= im_d;
    end
  end

endmodule

// ===== hdl/jet_ctrl.sv =====
// ----------------------------------------------------------------------------
// jet_ctrl
// Sequencer: runs the step loop (multiply, scale, add), counts steps, owns the handshakes.
// ----------------------------------------------------------------------------
`include "julia_escape_time_macros.svh"

module jet_ctrl import jet_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CountW-1:0] count_o,
  input  logic [LimitW-1:0] limit_i,
  input  status_t           status_i,
  output cmd_t              cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SCALE,
    S_ADD,
    S_WAIT
  } state_e;

  state_e            state_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] result_q;
  logic              out_valid_q;
  logic              last_step;
  logic [CountW-1:0] limit_x;
  logic              in_loop;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign count_o     = result_q;
  assign limit_x     = {1'b0, limit_i};
  assign last_step   = (count_q == limit_x);
  assign in_loop     = state_q inside {S_MUL, S_SCALE, S_ADD};

  assign cmd_o.load  = in_valid_i & in_ready_o;
  assign cmd_o.mul   = (state_q == S_MUL);
  assign cmd_o.scale = (state_q == S_SCALE);
  assign cmd_o.upd   = (state_q == S_ADD);

  // State, step counter and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      result_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // in S_WAIT the output register is handled below
      if (out_valid_q && out_ready_i && (state_q != S_WAIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            count_q <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL:   state_q <= S_SCALE;
        S_SCALE: state_q <= S_ADD;
        S_ADD: begin
          if (status_i.escape) begin
            state_q <= S_WAIT;
          end else begin
            // no escape: this step counts
            count_q <= count_q + 1'b1;
            state_q <= last_step ? S_WAIT : S_MUL;
          end
        end
        S_WAIT: begin
          if (!out_valid_q || out_ready_i) begin
            result_q    <= count_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `JET_ASSERT_NEXT(a_accept_starts, cmd_o.load, state_q == S_MUL, "no step after accept")
  `JET_ASSERT_NOW(a_count_in_loop, in_loop, count_q <= limit_x, "count past limit")
  `JET_ASSERT_NOW(a_result_range, out_valid_q, result_q <= limit_x + 1'b1, "result above limit+1")
  `JET_ASSERT_NEXT(a_add_after_scale, state_q == S_SCALE, state_q == S_ADD, "step sequence broken")

endmodule

// ===== hdl/julia_escape_time.sv =====
// ----------------------------------------------------------------------------
// julia_escape_time
// Julia-set escape-time counter in signed fixed point (Q6.26 by default).
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one request per start point; tdata = {start_imag, start_real}.
//   m_axis: one result per request; tdata[16:0] = step_count, upper bits zero.
//   APB: escape_bound at 0x0, c_real at 0x4, c_imag at 0x8,
//   iteration_limit at 0xC. Write only while the block is idle.
// Operation:
//   Each complex step runs through the shared datapath as products, then
//   scale and clamp, then add of c with bound test. A point runs n steps
//   (1 <= n <= iteration_limit + 1); no other request is taken until its
//   result is registered, and the next may be taken in the cycle it shows.
// Reset:
//   Registers return to bound 0, c 0, limit 10000; no result is pending.
// Stall:
//   The result sits in an output register. A new request may be accepted
//   and iterated while it waits; the next result is held until it is taken.
// ----------------------------------------------------------------------------
module julia_escape_time import jet_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Start point stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,  // [31:0] start_real, [63:32] start_imag
  // Result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,  // [16:0] step_count, [23:17] zero
  // Configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic signed [DataW-1:0] bound, c_real, c_imag;
  logic [LimitW-1:0]       limit;
  logic [CountW-1:0]       step_count;
  cmd_t                    cmd;
  status_t                 status;

  jet_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .bound_o  (bound),
    .c_real_o (c_real),
    .c_imag_o (c_imag),
    .limit_o  (limit)
  );

  jet_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .start_real_i (s_axis_tdata[31:0]),
    .start_imag_i (s_axis_tdata[63:32]),
    .bound_i      (bound),
    .c_real_i     (c_real),
    .c_imag_i     (c_imag),
    .cmd_i        (cmd),
    .status_o     (status)
  );

  jet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .count_o     (step_count),
    .limit_i     (limit),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  assign m_axis_tdata = {{(24-CountW){1'b0}}, step_count};

endmodule
